// ===== sv/fcm_pkg.sv =====
// Types and constants shared by the cluster chain manager and its checker.
package fcm_pkg;

   localparam logic [15:0] END_OF_CHAIN = 16'hFFFF;
   localparam logic [12:0] DBC_RESET = 13'd4096;

   localparam logic [2:0] OP_WALK = 3'd0;
   localparam logic [2:0] OP_EXTEND = 3'd1;
   localparam logic [2:0] OP_FREE = 3'd2;
   localparam logic [2:0] OP_COUNT = 3'd3;
   localparam logic [2:0] OP_SET = 3'd4;
   localparam logic [2:0] OP_GET = 3'd5;

   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_NO_FREE = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;

   typedef struct packed {
      logic [2:0]  operation;
      logic [15:0] chain_block;
      logic [12:0] walk_steps;
      logic [15:0] entry_value;
   } fcm_req_type;

   typedef struct packed {
      logic [15:0] result_block;
      logic [15:0] new_head;
      logic [12:0] free_count;
      logic [1:0]  status;
   } fcm_rsp_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_WALK,
      S_EXT_WALK,
      S_EXT_SCAN,
      S_EXT_MARK,
      S_EXT_LINK,
      S_FREE,
      S_COUNT,
      S_GET,
      S_RESP
   } fcm_state_type;

endpackage

// ===== sv/fat_chain_manager.sv =====
// File allocation table chain manager: walk, extend, free, count, set and get.
// One item at a time; each chain link or scanned entry costs one table read.
// After reset the table is swept to zero; items are held off during the sweep,
// register writes are taken throughout.
module fat_chain_manager #(
   parameter int TABLE_DEPTH = 4096
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  fcm_pkg::fcm_req_type req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output fcm_pkg::fcm_rsp_type rsp_payload,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [12:0]          csr_data
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (CW > 13) ? CW : 13;
   localparam logic [15:0]   DEPTH_BLK = 16'(TABLE_DEPTH);
   localparam logic [IW-1:0] DEPTH_ITER = IW'(TABLE_DEPTH);
   localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);

   fcm_pkg::fcm_state_type state_ff, state_in;
   fcm_pkg::fcm_req_type   item_ff, item_in;
   fcm_pkg::fcm_rsp_type   res_ff, res_in;
   fcm_pkg::fcm_rsp_type   rsp_payload_ff, rsp_payload_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [15:0]            cur_ff, cur_in;
   logic [15:0]            tail_ff, tail_in;
   logic [IW-1:0]          iter_ff, iter_in;
   logic [CW-1:0]          scan_ff, scan_in;
   logic [AW-1:0]          sa_ff, sa_in;
   logic                   pend_ff, pend_in;
   logic [12:0]            cnt_ff, cnt_in;
   logic [12:0]            dbc_ff, dbc_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic                   fwd_ff, fwd_in;
   logic [15:0]            fwd_data_ff;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [15:0]   wr_data;
   logic [AW-1:0] rd_addr;
   logic [15:0]   ram_rd_data;
   logic [15:0]   rd_fwd;

   logic [IW-1:0] lim_wide;
   logic [CW-1:0] lim;
   logic [15:0]   nxt_blk;
   logic          nxt_eoc, nxt_oor, iter_full, steps_done, scan_more;
   logic          hit_zero, tail_hit, in_range;

   fcm_ram #(
      .WIDTH(16),
      .DEPTH(TABLE_DEPTH)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(ram_rd_data)
   );

   // same-entry write and read in the same cycle: take the written value
   assign rd_fwd = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign fwd_in = wr_en && (wr_addr == rd_addr);

   assign lim_wide = (IW'(dbc_ff) > DEPTH_ITER) ? DEPTH_ITER : IW'(dbc_ff);
   assign lim = lim_wide[CW-1:0];

   assign nxt_blk = pend_ff ? rd_fwd : cur_ff;
   assign nxt_eoc = nxt_blk == fcm_pkg::END_OF_CHAIN;
   assign nxt_oor = nxt_blk >= DEPTH_BLK;
   assign iter_full = iter_ff == DEPTH_ITER;
   assign steps_done = iter_ff == IW'(item_ff.walk_steps);
   assign scan_more = scan_ff < lim;
   assign hit_zero = pend_ff && (rd_fwd == 16'd0);
   assign tail_hit = pend_ff && (rd_fwd == fcm_pkg::END_OF_CHAIN);
   assign in_range = item_ff.chain_block < DEPTH_BLK;

   assign req_stall = state_ff != fcm_pkg::S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;
   assign csr_ready = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         fcm_pkg::S_CLEAR: begin
            if (clr_ff == LAST_ADDR) state_in = fcm_pkg::S_IDLE;
         end
         fcm_pkg::S_IDLE: begin
            if (req_valid) state_in = fcm_pkg::S_DECODE;
         end
         fcm_pkg::S_DECODE: begin
            case (item_ff.operation)
               fcm_pkg::OP_WALK: state_in = fcm_pkg::S_WALK;
               fcm_pkg::OP_EXTEND: begin
                  state_in = (item_ff.chain_block == fcm_pkg::END_OF_CHAIN) ?
                             fcm_pkg::S_EXT_SCAN : fcm_pkg::S_EXT_WALK;
               end
               fcm_pkg::OP_FREE: state_in = fcm_pkg::S_FREE;
               fcm_pkg::OP_COUNT: state_in = fcm_pkg::S_COUNT;
               fcm_pkg::OP_GET: state_in = in_range ? fcm_pkg::S_GET : fcm_pkg::S_RESP;
               default: state_in = fcm_pkg::S_RESP;
            endcase
         end
         fcm_pkg::S_WALK: begin
            if (steps_done || nxt_eoc || nxt_oor) state_in = fcm_pkg::S_RESP;
         end
         fcm_pkg::S_EXT_WALK: begin
            if (tail_hit) state_in = fcm_pkg::S_EXT_SCAN;
            else if (nxt_oor || iter_full) state_in = fcm_pkg::S_RESP;
         end
         fcm_pkg::S_EXT_SCAN: begin
            if (hit_zero) state_in = fcm_pkg::S_EXT_MARK;
            else if (!scan_more) state_in = fcm_pkg::S_RESP;
         end
         fcm_pkg::S_EXT_MARK: begin
            state_in = (tail_ff == fcm_pkg::END_OF_CHAIN) ?
                       fcm_pkg::S_RESP : fcm_pkg::S_EXT_LINK;
         end
         fcm_pkg::S_EXT_LINK: state_in = fcm_pkg::S_RESP;
         fcm_pkg::S_FREE: begin
            if (nxt_eoc || nxt_oor || iter_full) state_in = fcm_pkg::S_RESP;
         end
         fcm_pkg::S_COUNT: begin
            if (!scan_more && !pend_ff) state_in = fcm_pkg::S_RESP;
         end
         fcm_pkg::S_GET: state_in = fcm_pkg::S_RESP;
         fcm_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) state_in = fcm_pkg::S_IDLE;
         end
         default: state_in = fcm_pkg::S_IDLE;
      endcase
   end

   always_comb begin
      item_in = item_ff;
      res_in = res_ff;
      cur_in = cur_ff;
      tail_in = tail_ff;
      iter_in = iter_ff;
      scan_in = scan_ff;
      sa_in = sa_ff;
      pend_in = pend_ff;
      cnt_in = cnt_ff;
      clr_in = clr_ff;
      dbc_in = csr_valid ? csr_data : dbc_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_payload_in = rsp_payload_ff;
      wr_en = 1'b0;
      wr_addr = cur_ff[AW-1:0];
      wr_data = 16'd0;
      rd_addr = nxt_blk[AW-1:0];
      case (state_ff)
         fcm_pkg::S_CLEAR: begin
            wr_en = 1'b1;
            wr_addr = clr_ff;
            clr_in = clr_ff + 1'b1;
         end
         fcm_pkg::S_IDLE: begin
            if (req_valid) item_in = req_payload;
         end
         fcm_pkg::S_DECODE: begin
            cur_in = item_ff.chain_block;
            tail_in = fcm_pkg::END_OF_CHAIN;
            pend_in = 1'b0;
            iter_in = '0;
            scan_in = '0;
            cnt_in = '0;
            res_in = '0;
            case (item_ff.operation)
               fcm_pkg::OP_EXTEND: begin
                  res_in.result_block = fcm_pkg::END_OF_CHAIN;
                  res_in.new_head = item_ff.chain_block;
               end
               fcm_pkg::OP_SET: begin
                  if (in_range) begin
                     wr_en = 1'b1;
                     wr_addr = item_ff.chain_block[AW-1:0];
                     wr_data = item_ff.entry_value;
                  end else begin
                     res_in.status = fcm_pkg::ST_RANGE;
                  end
               end
               fcm_pkg::OP_GET: begin
                  rd_addr = item_ff.chain_block[AW-1:0];
                  if (!in_range) res_in.status = fcm_pkg::ST_RANGE;
               end
               default: ;
            endcase
         end
         fcm_pkg::S_WALK: begin
            cur_in = nxt_blk;
            pend_in = 1'b0;
            if (steps_done || nxt_eoc) begin
               res_in.result_block = nxt_blk;
            end else if (nxt_oor) begin
               res_in.result_block = nxt_blk;
               res_in.status = fcm_pkg::ST_RANGE;
            end else begin
               pend_in = 1'b1;
               iter_in = iter_ff + 1'b1;
            end
         end
         fcm_pkg::S_EXT_WALK: begin
            if (tail_hit) begin
               tail_in = cur_ff;
               pend_in = 1'b0;
            end else if (nxt_oor || iter_full) begin
               res_in.status = fcm_pkg::ST_RANGE;
            end else begin
               cur_in = nxt_blk;
               pend_in = 1'b1;
               iter_in = iter_ff + 1'b1;
            end
         end
         fcm_pkg::S_EXT_SCAN: begin
            rd_addr = scan_ff[AW-1:0];
            if (hit_zero) begin
               cur_in = 16'(sa_ff);
               pend_in = 1'b0;
            end else if (!scan_more) begin
               res_in.status = fcm_pkg::ST_NO_FREE;
            end else begin
               sa_in = scan_ff[AW-1:0];
               scan_in = scan_ff + 1'b1;
               pend_in = 1'b1;
            end
         end
         fcm_pkg::S_EXT_MARK: begin
            wr_en = 1'b1;
            wr_data = fcm_pkg::END_OF_CHAIN;
            res_in.result_block = cur_ff;
            if (tail_ff == fcm_pkg::END_OF_CHAIN) res_in.new_head = cur_ff;
         end
         fcm_pkg::S_EXT_LINK: begin
            wr_en = 1'b1;
            wr_addr = tail_ff[AW-1:0];
            wr_data = cur_ff;
         end
         fcm_pkg::S_FREE: begin
            wr_en = pend_ff;
            cur_in = nxt_blk;
            pend_in = 1'b0;
            if (nxt_eoc) begin
               res_in.status = fcm_pkg::ST_OK;
            end else if (nxt_oor || iter_full) begin
               res_in.status = fcm_pkg::ST_RANGE;
            end else begin
               pend_in = 1'b1;
               iter_in = iter_ff + 1'b1;
            end
         end
         fcm_pkg::S_COUNT: begin
            rd_addr = scan_ff[AW-1:0];
            if (hit_zero) cnt_in = cnt_ff + 1'b1;
            pend_in = scan_more;
            if (scan_more) scan_in = scan_ff + 1'b1;
            if (!scan_more && !pend_ff) res_in.free_count = cnt_ff;
         end
         fcm_pkg::S_GET: begin
            res_in.result_block = rd_fwd;
         end
         fcm_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_payload_in = res_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= fcm_pkg::S_CLEAR;
         rsp_valid_ff <= 1'b0;
         dbc_ff <= fcm_pkg::DBC_RESET;
         clr_ff <= '0;
         pend_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         dbc_ff <= dbc_in;
         clr_ff <= clr_in;
         pend_ff <= pend_in;
         fwd_ff <= fwd_in;
      end
      item_ff <= item_in;
      res_ff <= res_in;
      rsp_payload_ff <= rsp_payload_in;
      cur_ff <= cur_in;
      tail_ff <= tail_in;
      iter_ff <= iter_in;
      scan_ff <= scan_in;
      sa_ff <= sa_in;
      cnt_ff <= cnt_in;
      fwd_data_ff <= wr_data;
   end

endmodule

// ===== sv/fcm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module fcm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/fcm_checker.sv =====
// Port-level checks for the cluster chain manager, bound to its top level.
module fcm_checker (
   input logic                 clock,
   input logic                 reset,
   input logic                 req_stall,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input fcm_pkg::fcm_rsp_type rsp_payload
);

   // table sweep holds off items straight after reset
   a_stall_after_reset: assert property (@(posedge clock) reset |=> req_stall)
      else $error("item taken during table sweep");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result item changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_payload.status == fcm_pkg::ST_OK ||
      rsp_payload.status == fcm_pkg::ST_NO_FREE || rsp_payload.status == fcm_pkg::ST_RANGE)
      else $error("undefined status code");

   a_no_free: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == fcm_pkg::ST_NO_FREE |->
      rsp_payload.result_block == fcm_pkg::END_OF_CHAIN && rsp_payload.free_count == 13'd0)
      else $error("failed extend returned a block");

   a_range_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.status == fcm_pkg::ST_RANGE |->
      rsp_payload.free_count == 13'd0)
      else $error("range error with a free count");

endmodule

bind fat_chain_manager fcm_checker u_fcm_checker (.*);

// ===== tb/fat_chain_manager_tb.sv =====
// Self-checking testbench for fat_chain_manager: table mirror, directed and random items.
module fat_chain_manager_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = 4096;
   localparam int QUIET_LIMIT = 40000;

   class fat_mirror;
      logic [15:0]          links [DEPTH];
      logic [12:0]          block_count;
      fcm_pkg::fcm_rsp_type awaited [$];
      int                   mismatches;
      int                   checked;
      int                   op_tally [8];

      function new();
         foreach (links[i]) links[i] = '0;
         foreach (op_tally[i]) op_tally[i] = 0;
         block_count = fcm_pkg::DBC_RESET;
         mismatches = 0;
         checked = 0;
      endfunction

      // works out the result of one accepted item and updates the table copy
      function fcm_pkg::fcm_rsp_type take_request(fcm_pkg::fcm_req_type r);
         fcm_pkg::fcm_rsp_type o;
         int unsigned cur, nxt, tail, nb, lim, cnt;
         int          i;
         bit          done;
         o = '0;
         lim = (block_count > DEPTH) ? DEPTH : block_count;
         op_tally[r.operation]++;
         case (r.operation)
            fcm_pkg::OP_WALK: begin
               cur = r.chain_block;
               for (i = 0; i < r.walk_steps; i++) begin
                  if (cur == fcm_pkg::END_OF_CHAIN) break;
                  if (cur >= DEPTH) begin
                     o.status = fcm_pkg::ST_RANGE;
                     break;
                  end
                  cur = links[cur];
               end
               o.result_block = cur[15:0];
            end
            fcm_pkg::OP_EXTEND: begin
               o.result_block = fcm_pkg::END_OF_CHAIN;
               o.new_head = r.chain_block;
               tail = fcm_pkg::END_OF_CHAIN;
               done = 1'b1;
               if (r.chain_block != fcm_pkg::END_OF_CHAIN) begin
                  done = 1'b0;
                  cur = r.chain_block;
                  for (i = 0; i < DEPTH; i++) begin
                     if (cur >= DEPTH) break;
                     if (links[cur] == fcm_pkg::END_OF_CHAIN) begin
                        tail = cur;
                        done = 1'b1;
                        break;
                     end
                     cur = links[cur];
                  end
               end
               if (!done) begin
                  o.status = fcm_pkg::ST_RANGE;
               end else begin
                  nb = fcm_pkg::END_OF_CHAIN;
                  for (i = 0; i < lim; i++) begin
                     if (links[i] == 16'd0) begin
                        nb = i;
                        break;
                     end
                  end
                  if (nb == fcm_pkg::END_OF_CHAIN) begin
                     o.status = fcm_pkg::ST_NO_FREE;
                  end else begin
                     links[nb] = fcm_pkg::END_OF_CHAIN;
                     if (tail == fcm_pkg::END_OF_CHAIN) o.new_head = nb[15:0];
                     else links[tail] = nb[15:0];
                     o.result_block = nb[15:0];
                  end
               end
            end
            fcm_pkg::OP_FREE: begin
               cur = r.chain_block;
               for (i = 0; i < DEPTH; i++) begin
                  if (cur == fcm_pkg::END_OF_CHAIN || cur >= DEPTH) break;
                  nxt = links[cur];
                  links[cur] = '0;
                  cur = nxt;
               end
               if (cur != fcm_pkg::END_OF_CHAIN) o.status = fcm_pkg::ST_RANGE;
            end
            fcm_pkg::OP_COUNT: begin
               cnt = 0;
               for (i = 0; i < lim; i++)
                  if (links[i] == 16'd0) cnt++;
               o.free_count = (cnt > 8191) ? 13'd8191 : 13'(cnt);
            end
            fcm_pkg::OP_SET: begin
               if (r.chain_block < DEPTH) links[r.chain_block] = r.entry_value;
               else o.status = fcm_pkg::ST_RANGE;
            end
            fcm_pkg::OP_GET: begin
               if (r.chain_block < DEPTH) o.result_block = links[r.chain_block];
               else o.status = fcm_pkg::ST_RANGE;
            end
            default: ;
         endcase
         awaited.push_back(o);
         return o;
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %h, got %h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_response(fcm_pkg::fcm_rsp_type got);
         fcm_pkg::fcm_rsp_type want;
         if (awaited.size() == 0) begin
            $display("%0t: result with none outstanding, expected nothing, got %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = awaited.pop_front();
         checked++;
         compare_field("result_block", want.result_block, got.result_block);
         compare_field("new_head", want.new_head, got.new_head);
         compare_field("free_count", want.free_count, got.free_count);
         compare_field("status", want.status, got.status);
      endfunction
   endclass

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   fcm_pkg::fcm_req_type req_payload;
   logic                 rsp_valid;
   logic                 rsp_stall;
   fcm_pkg::fcm_rsp_type rsp_payload;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [12:0]          csr_data;

   fat_mirror   mirror;
   int          idle_pct = 0;
   int          stall_pct = 0;
   int          quiet_cycles = 0;
   logic [15:0] chain_heads [$];

   fat_chain_manager #(.TABLE_DEPTH(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         mirror.check_response(rsp_payload);
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
      $display("fat_chain_manager: mismatch");
      $finish;
   end

   task automatic send_req(input fcm_pkg::fcm_req_type r, output fcm_pkg::fcm_rsp_type p);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (req_stall);
      p = mirror.take_request(r);
   endtask

   task automatic run_op(input logic [2:0] op, input logic [15:0] blk,
                         input logic [12:0] steps, input logic [15:0] val);
      fcm_pkg::fcm_req_type r;
      fcm_pkg::fcm_rsp_type p;
      r.operation = op;
      r.chain_block = blk;
      r.walk_steps = steps;
      r.entry_value = val;
      send_req(r, p);
   endtask

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (mirror.awaited.size() != 0);
   endtask

   task automatic write_block_count(input logic [12:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      mirror.block_count = v;
   endtask

   // mostly operations on live chains, with some corrupting writes and stray blocks
   task automatic random_request();
      fcm_pkg::fcm_req_type r;
      fcm_pkg::fcm_rsp_type p;
      int                   pick;
      int                   idx;
      r.operation = fcm_pkg::OP_WALK;
      r.chain_block = 16'($urandom);
      r.walk_steps = 13'($urandom);
      r.entry_value = 16'($urandom);
      pick = $urandom_range(99);
      if (pick < 30) begin
         r.operation = fcm_pkg::OP_EXTEND;
         if (chain_heads.size() == 0 || $urandom_range(3) == 0)
            r.chain_block = fcm_pkg::END_OF_CHAIN;
         else
            r.chain_block = chain_heads[$urandom_range(chain_heads.size() - 1)];
      end else if (pick < 50) begin
         r.operation = fcm_pkg::OP_WALK;
         r.chain_block = (chain_heads.size() == 0) ? fcm_pkg::END_OF_CHAIN :
                         chain_heads[$urandom_range(chain_heads.size() - 1)];
         if ($urandom_range(19) != 0) r.walk_steps = 13'($urandom_range(6));
      end else if (pick < 60) begin
         r.operation = fcm_pkg::OP_FREE;
         r.chain_block = fcm_pkg::END_OF_CHAIN;
         if (chain_heads.size() != 0) begin
            idx = $urandom_range(chain_heads.size() - 1);
            r.chain_block = chain_heads[idx];
            chain_heads.delete(idx);
         end
      end else if (pick < 67) begin
         r.operation = fcm_pkg::OP_COUNT;
      end else if (pick < 77) begin
         r.operation = fcm_pkg::OP_GET;
         if ($urandom_range(3) != 0) r.chain_block = 16'($urandom_range(63));
      end else if (pick < 87) begin
         r.operation = fcm_pkg::OP_SET;
         if ($urandom_range(4) != 0) r.chain_block = 16'($urandom_range(63));
         case ($urandom_range(3))
            0: r.entry_value = fcm_pkg::END_OF_CHAIN;
            1: r.entry_value = '0;
            2: r.entry_value = 16'($urandom_range(63));
            default: ;
         endcase
      end else if (pick < 95) begin
         r.operation = $urandom_range(1) ? fcm_pkg::OP_WALK : fcm_pkg::OP_FREE;
         r.walk_steps = 13'($urandom_range(4));
      end else begin
         r.operation = 3'($urandom_range(6, 7));
      end
      send_req(r, p);
      if (r.operation == fcm_pkg::OP_EXTEND && r.chain_block == fcm_pkg::END_OF_CHAIN &&
          p.status == fcm_pkg::ST_OK)
         chain_heads.push_back(p.new_head);
   endtask

   initial begin
      logic [12:0] dbc;
      int          items;
      mirror = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_payload <= '0;
      csr_valid <= 1'b0;
      csr_data <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: field extremes, range errors, loops and runaway chains
      run_op(fcm_pkg::OP_COUNT, 16'd0, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_GET, 16'd0, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_GET, 16'd4095, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_GET, fcm_pkg::END_OF_CHAIN, 13'd8191, 16'hFFFF);
      run_op(fcm_pkg::OP_SET, 16'd4096, 13'd0, 16'h1234);
      run_op(fcm_pkg::OP_EXTEND, fcm_pkg::END_OF_CHAIN, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_EXTEND, 16'd0, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_EXTEND, 16'd0, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_WALK, 16'd0, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_WALK, 16'd0, 13'd2, 16'd0);
      run_op(fcm_pkg::OP_WALK, 16'd0, 13'd8191, 16'd0);
      run_op(fcm_pkg::OP_WALK, fcm_pkg::END_OF_CHAIN, 13'd5, 16'd0);
      run_op(fcm_pkg::OP_WALK, 16'd5000, 13'd1, 16'd0);
      run_op(fcm_pkg::OP_SET, 16'd4095, 13'd0, fcm_pkg::END_OF_CHAIN);
      run_op(fcm_pkg::OP_SET, 16'd10, 13'd0, 16'd40000);
      run_op(fcm_pkg::OP_WALK, 16'd10, 13'd3, 16'd0);
      run_op(fcm_pkg::OP_EXTEND, 16'd10, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_FREE, 16'd10, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_SET, 16'd20, 13'd0, 16'd20);
      run_op(fcm_pkg::OP_EXTEND, 16'd20, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_WALK, 16'd20, 13'd4096, 16'd0);
      run_op(fcm_pkg::OP_FREE, 16'd20, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_FREE, 16'd20, 13'd0, 16'd0);
      run_op(fcm_pkg::OP_FREE, fcm_pkg::END_OF_CHAIN, 13'd0, 16'd0);
      run_op(3'd6, 16'($urandom), 13'($urandom), 16'($urandom));
      run_op(3'd7, 16'($urandom), 13'($urandom), 16'($urandom));

      for (int ph = 0; ph < 6; ph++) begin
         wait_for_drain();
         case (ph)
            0: begin dbc = 13'd8191; items = 25; idle_pct = 0;  stall_pct = 0;  end
            1: begin dbc = 13'd1;    items = 10; idle_pct = 57; stall_pct = 0;  end
            2: begin dbc = 13'd16;   items = 25; idle_pct = 0;  stall_pct = 57; end
            3: begin dbc = 13'd0;    items = 10; idle_pct = 35; stall_pct = 35; end
            4: begin
               dbc = 13'($urandom_range(2, 4095));
               items = 20; idle_pct = 35; stall_pct = 35;
            end
            default: begin dbc = 13'd4096; items = 25; idle_pct = 0; stall_pct = 57; end
         endcase
         write_block_count(dbc);
         for (int k = 0; k < items; k++) begin
            random_request();
            if (k == items / 2) wait_for_drain();
         end
      end

      wait_for_drain();
      repeat (20) @(posedge clock);
      $display("Sent walk %0d, extend %0d, free %0d, count %0d, set %0d, get %0d, unused %0d",
               mirror.op_tally[fcm_pkg::OP_WALK], mirror.op_tally[fcm_pkg::OP_EXTEND],
               mirror.op_tally[fcm_pkg::OP_FREE], mirror.op_tally[fcm_pkg::OP_COUNT],
               mirror.op_tally[fcm_pkg::OP_SET], mirror.op_tally[fcm_pkg::OP_GET],
               mirror.op_tally[6] + mirror.op_tally[7]);
      $display("%0d results checked over block limits 4096, 8191, 1, 16, 0, random; %0d errors",
               mirror.checked, mirror.mismatches);
      if (mirror.mismatches == 0 && mirror.awaited.size() == 0)
         $display("fat_chain_manager: match");
      else
         $display("fat_chain_manager: mismatch");
      $finish;
   end

endmodule
